[sv/u16u8_pkg.sv]
// Shared types and constants for the UTF-16BE to UTF-8 stream unit.
package u16u8_pkg;

   localparam int UnitWidth   = 16;
   localparam int BudgetWidth = 8;
   localparam int MaxBytes    = 3;

   localparam logic [BudgetWidth-1:0] BudgetReset = 8'd255;

   localparam logic [7:0] LeadTwo   = 8'hC0;
   localparam logic [7:0] LeadThree = 8'hE0;
   localparam logic [7:0] ContMark  = 8'h80;
   localparam logic [5:0] ContMask  = 6'h3F;

   // Name status carried on every result beat.
   typedef enum logic [1:0] {
      ST_CONV   = 2'd0,
      ST_ZERO   = 2'd1,
      ST_BUDGET = 2'd2
   } status_type;

   // One converted unit as handed from the core to the output sequencer.
   typedef struct packed {
      logic [8*MaxBytes-1:0] bytes;      // first byte in the low bits
      logic [1:0]            count;      // beats to send, 1 to 3
      logic                  byte_valid;
      status_type            status;
   } result_type;

endpackage

[sv/u16u8_core.sv]
// Budget and status state plus the UTF-8 encoding of one code unit.
module u16u8_core
   import u16u8_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [BudgetWidth-1:0] csr_value,
   input  logic                   take,
   input  logic [UnitWidth-1:0]   code_unit,
   input  logic                   last_unit,
   output result_type             res
);

   logic [BudgetWidth-1:0] max_ff, max_in;
   logic [BudgetWidth-1:0] budget_ff, budget_in, budget_upd;
   status_type             ended_ff, ended_in, ended_eff, ended_upd;
   logic [8*MaxBytes-1:0]  enc_bytes;
   logic [1:0]             enc_count;
   logic                   over;

   // Encoding of the unit on its own; surrogates are not paired.
   always_comb begin
      if (code_unit < 16'h0080) begin
         enc_bytes = {16'h0000, code_unit[7:0]};
         enc_count = 2'd1;
      end else if (code_unit < 16'h0800) begin
         enc_bytes = {8'h00, ContMark | {2'b00, code_unit[5:0] & ContMask},
                      LeadTwo | {3'b000, code_unit[10:6]}};
         enc_count = 2'd2;
      end else begin
         enc_bytes = {ContMark | {2'b00, code_unit[5:0]},
                      ContMark | {2'b00, code_unit[11:6]},
                      LeadThree | {4'h0, code_unit[15:12]}};
         enc_count = 2'd3;
      end
      over = {{(BudgetWidth-2){1'b0}}, enc_count} > budget_ff;
   end

   always_comb begin
      ended_eff = ended_ff;
      if (ended_ff == ST_CONV && budget_ff == '0) begin
         ended_eff = ST_BUDGET;
      end

      res.bytes      = '0;
      res.count      = 2'd1;
      res.byte_valid = 1'b0;
      res.status     = ended_eff;
      budget_upd     = budget_ff;
      ended_upd      = ended_eff;

      if (ended_eff != ST_CONV) begin
         // Name already over: one empty beat with the stored status.
      end else if (code_unit == '0) begin
         ended_upd  = ST_ZERO;
         res.status = ST_ZERO;
      end else if (over) begin
         // The character is dropped but still costs one unit.
         budget_upd = budget_ff - 8'd1;
         ended_upd  = (budget_upd == '0) ? ST_BUDGET : ST_CONV;
         res.status = ended_upd;
      end else begin
         budget_upd     = budget_ff - {{(BudgetWidth-2){1'b0}}, enc_count};
         ended_upd      = (budget_upd == '0) ? ST_BUDGET : ST_CONV;
         res.status     = ended_upd;
         res.bytes      = enc_bytes;
         res.count      = enc_count;
         res.byte_valid = 1'b1;
      end

      max_in    = max_ff;
      budget_in = budget_ff;
      ended_in  = ended_ff;
      if (csr_write) begin
         max_in    = csr_value;
         budget_in = csr_value;
      end else if (take) begin
         if (last_unit) begin
            budget_in = max_ff;
            ended_in  = ST_CONV;
         end else begin
            budget_in = budget_upd;
            ended_in  = ended_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= BudgetReset;
         budget_ff <= BudgetReset;
         ended_ff  <= ST_CONV;
      end else begin
         max_ff    <= max_in;
         budget_ff <= budget_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

[sv/u16u8_emit.sv]
// Result register and byte sequencer that sends one beat per cycle while rsp_tready is high.
module u16u8_emit
   import u16u8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res,
   output logic       load_ok,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [2:0] rsp_tuser,   // byte_valid, end_status[1:0]
   output logic       rsp_tlast    // last_of_run
);

   logic                  busy_ff, busy_in;
   logic [1:0]            rem_ff, rem_in;
   logic [8*MaxBytes-1:0] data_ff, data_in;
   logic                  flag_ff, flag_in;
   status_type            status_ff, status_in;

   // A new unit may load while the final beat of the previous one leaves.
   assign load_ok = !busy_ff || (rsp_tready && rem_ff == 2'd1);

   always_comb begin
      busy_in   = busy_ff;
      rem_in    = rem_ff;
      data_in   = data_ff;
      flag_in   = flag_ff;
      status_in = status_ff;
      if (load) begin
         busy_in   = 1'b1;
         rem_in    = res.count;
         data_in   = res.bytes;
         flag_in   = res.byte_valid;
         status_in = res.status;
      end else if (busy_ff && rsp_tready) begin
         busy_in = (rem_ff != 2'd1);
         rem_in  = rem_ff - 2'd1;
         data_in = {8'h00, data_ff[8*MaxBytes-1:8]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rem_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      flag_ff   <= flag_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = data_ff[7:0];
   assign rsp_tuser  = {status_ff, flag_ff};
   assign rsp_tlast  = (rem_ff == 2'd1);

endmodule

[sv/utf16be_to_utf8_stream_unit.sv]
// Top level: UTF-16BE code units in, UTF-8 bytes out under a per-name byte budget.
// The first result beat of a unit is valid in the cycle after its input beat.
// One result beat per cycle while rsp_tready is high; a unit sends one to three beats,
// set by its UTF-8 length, through the single result register.
// Reset (synchronous, active high) sets the budget register to 255, reloads the
// budget, clears the name status and empties the output register.
module utf16be_to_utf8_stream_unit
   import u16u8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,    // max_out_bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // code_unit
   input  logic        req_tlast,   // last_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic [2:0]  rsp_tuser,   // byte_valid, end_status[1:0]
   output logic        rsp_tlast    // last_of_run
);

   result_type res;
   logic       load_ok;
   logic       take;

   assign csr_ready  = 1'b1;
   assign req_tready = load_ok;
   assign take       = req_tvalid && load_ok;

   u16u8_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_value (csr_data),
      .take      (take),
      .code_unit (req_tdata),
      .last_unit (req_tlast),
      .res       (res)
   );

   u16u8_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .res        (res),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // An accepted unit always shows a result beat in the next cycle.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted unit produced no result beat");

   // An empty result is always a single, final beat.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast)
      else $error("empty result beat not marked last");

   // Any byte that is not the last of its character is a lead or continuation byte.
   a_multibyte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] && !rsp_tlast) |-> rsp_tdata[7])
      else $error("non-final byte of a character lacks the high bit");

   // The status stays the same on all beats of one unit.
   a_status_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tuser[2:1] == $past(rsp_tuser[2:1])))
      else $error("status changed within one unit's beats");
`endif

endmodule
